### hw/rtl/itr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itr_pkg
// Shared types, constants and the digit-to-ASCII mapping for the radix
// digit converter.
// ----------------------------------------------------------------------------
package itr_pkg;

   localparam int VALUE_WIDTH = 63;
   localparam int RADIX_WIDTH = 6;
   localparam int DIGIT_WIDTH = 6;
   localparam int CHAR_WIDTH  = 7;

   // quotient bits retired per divider cycle
   localparam int DIV_STEPS = 8;

   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX = 6'd36;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_TEN = 6'd10;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_TOP = 6'd35;
   localparam logic [CHAR_WIDTH-1:0]  CHAR_ZERO = 7'd48;
   localparam logic [CHAR_WIDTH-1:0]  CHAR_A    = 7'd65;

   typedef enum logic [1:0] {
      KIND_ERROR   = 2'd0,
      KIND_ZERO    = 2'd1,
      KIND_CONVERT = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [RADIX_WIDTH-1:0]  radix;
   } item_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_DIV  = 2'd1,
      ST_POP  = 2'd2
   } back_state_type;

   function automatic logic [CHAR_WIDTH-1:0] digit_to_ascii(input logic [DIGIT_WIDTH-1:0] d);
      logic [CHAR_WIDTH-1:0] ch;
      if (d < DIGIT_TEN) begin
         ch = CHAR_ZERO + CHAR_WIDTH'(d);
      end else if (d <= DIGIT_TOP) begin
         ch = CHAR_A + CHAR_WIDTH'(d - DIGIT_TEN);
      end else begin
         ch = '0;
      end
      return ch;
   endfunction

endpackage

### hw/rtl/itr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itr_front
// Takes requests, masks the value and classifies each request as bad radix,
// zero or conversion, then hands it to the queue.
// ----------------------------------------------------------------------------
module itr_front #(
   parameter int VALUE_BITS = 63
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [itr_pkg::VALUE_WIDTH-1:0]       req_value,
   input  logic [itr_pkg::RADIX_WIDTH-1:0]       req_radix,
   output logic                                  push,
   input  logic                                  queue_full,
   output itr_pkg::item_ctl_type                 push_ctl,
   output logic [VALUE_BITS-1:0]                 push_value
);

   logic                      hold_vld_ff, hold_vld_in;
   itr_pkg::item_ctl_type     hold_ctl_ff, hold_ctl_in;
   logic [VALUE_BITS-1:0]     hold_value_ff, hold_value_in;
   logic                      accept;
   logic [VALUE_BITS-1:0]     masked;

   assign busy   = hold_vld_ff && queue_full;
   assign accept = start && !busy;
   assign push   = hold_vld_ff && !queue_full;
   assign masked = req_value[VALUE_BITS-1:0];

   always_comb begin
      hold_vld_in   = hold_vld_ff;
      hold_ctl_in   = hold_ctl_ff;
      hold_value_in = hold_value_ff;
      if (push) begin
         hold_vld_in = 1'b0;
      end
      if (accept) begin
         hold_vld_in       = 1'b1;
         hold_value_in     = masked;
         hold_ctl_in.radix = req_radix;
         if (req_radix < itr_pkg::RADIX_MIN || req_radix > itr_pkg::RADIX_MAX) begin
            hold_ctl_in.kind = itr_pkg::KIND_ERROR;
         end else if (masked == '0) begin
            hold_ctl_in.kind = itr_pkg::KIND_ZERO;
         end else begin
            hold_ctl_in.kind = itr_pkg::KIND_CONVERT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
      end else begin
         hold_vld_ff <= hold_vld_in;
      end
      hold_ctl_ff   <= hold_ctl_in;
      hold_value_ff <= hold_value_in;
   end

   assign push_ctl   = hold_ctl_ff;
   assign push_value = hold_value_ff;

endmodule

### hw/rtl/itr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itr_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module itr_queue #(
   parameter int DATA_BITS = 71
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [DATA_BITS-1:0]  push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output logic [DATA_BITS-1:0]  pop_data
);

   logic [DATA_BITS-1:0] entry_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/itr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itr_back
// Repeated division by the radix, several quotient bits per cycle, with
// remainders pushed on a digit stack, then popped most significant first.
// ----------------------------------------------------------------------------
module itr_back #(
   parameter int VALUE_BITS = 63,
   parameter int MAX_DIGITS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 queue_empty,
   output logic                                 deq,
   input  itr_pkg::item_ctl_type                item_ctl,
   input  logic [VALUE_BITS-1:0]                item_value,
   output logic                                 rsp_strobe,
   output logic [itr_pkg::CHAR_WIDTH-1:0]       rsp_digit_char,
   output logic                                 rsp_last,
   output logic                                 rsp_error
);

   localparam int STEPS   = itr_pkg::DIV_STEPS;
   localparam int CHUNKS  = (VALUE_BITS + STEPS - 1) / STEPS;
   localparam int QW      = CHUNKS * STEPS;
   localparam int CHUNK_W = $clog2(CHUNKS + 1);
   localparam int CNT_W   = $clog2(MAX_DIGITS + 1);
   localparam int AW      = $clog2(MAX_DIGITS);
   localparam int DW      = itr_pkg::DIGIT_WIDTH;
   localparam int RW      = itr_pkg::RADIX_WIDTH;

   itr_pkg::back_state_type state_ff, state_in;

   logic [QW-1:0]        q_ff, q_in, q_nx;
   logic [DW-1:0]        rem_ff, rem_in, r_nx;
   logic [RW-1:0]        radix_ff, radix_in;
   logic [CHUNK_W-1:0]   chunk_ff, chunk_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in, cnt_dec;

   logic [DW-1:0]        stack_mem [MAX_DIGITS];
   logic [DW-1:0]        mem_q_ff;
   logic                 push_en;
   logic [AW-1:0]        wr_addr, rd_addr;

   logic                 pop_vld_ff, pop_vld_in;
   logic                 pop_last_ff, pop_last_in;
   logic                 pop_err_ff, pop_err_in;
   logic                 pop_zero_ff, pop_zero_in;

   logic                 rsp_strobe_ff;
   logic [itr_pkg::CHAR_WIDTH-1:0] rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff;
   logic                 rsp_error_ff;
   logic [DW-1:0]        out_digit;

   // restoring division, STEPS quotient bits per cycle
   always_comb begin
      logic [DW:0] t;
      q_nx = q_ff;
      r_nx = rem_ff;
      for (int i = 0; i < STEPS; i++) begin
         t    = {r_nx, q_nx[QW-1]};
         q_nx = {q_nx[QW-2:0], 1'b0};
         if (t >= {1'b0, radix_ff}) begin
            t       = t - {1'b0, radix_ff};
            q_nx[0] = 1'b1;
         end
         r_nx = t[DW-1:0];
      end
   end

   assign cnt_dec = cnt_ff - CNT_W'(1);
   assign rd_addr = cnt_dec[AW-1:0];
   assign wr_addr = cnt_ff[AW-1:0];

   always_comb begin
      state_in    = state_ff;
      q_in        = q_ff;
      rem_in      = rem_ff;
      radix_in    = radix_ff;
      chunk_in    = chunk_ff;
      cnt_in      = cnt_ff;
      deq         = 1'b0;
      push_en     = 1'b0;
      pop_vld_in  = 1'b0;
      pop_last_in = 1'b0;
      pop_err_in  = 1'b0;
      pop_zero_in = 1'b0;
      unique case (state_ff)
         itr_pkg::ST_IDLE: begin
            if (!queue_empty) begin
               deq = 1'b1;
               unique case (item_ctl.kind)
                  itr_pkg::KIND_ZERO: begin
                     pop_vld_in  = 1'b1;
                     pop_last_in = 1'b1;
                     pop_zero_in = 1'b1;
                  end
                  itr_pkg::KIND_CONVERT: begin
                     q_in     = QW'(item_value);
                     radix_in = item_ctl.radix;
                     rem_in   = '0;
                     chunk_in = '0;
                     cnt_in   = '0;
                     state_in = itr_pkg::ST_DIV;
                  end
                  default: begin
                     pop_vld_in  = 1'b1;
                     pop_last_in = 1'b1;
                     pop_err_in  = 1'b1;
                  end
               endcase
            end
         end
         itr_pkg::ST_DIV: begin
            q_in   = q_nx;
            rem_in = r_nx;
            if (chunk_ff == CHUNK_W'(CHUNKS - 1)) begin
               chunk_in = '0;
               rem_in   = '0;
               if (cnt_ff < CNT_W'(MAX_DIGITS)) begin
                  push_en = 1'b1;
                  cnt_in  = cnt_ff + CNT_W'(1);
               end
               if (q_nx == '0) begin
                  state_in = itr_pkg::ST_POP;
               end
            end else begin
               chunk_in = chunk_ff + CHUNK_W'(1);
            end
         end
         itr_pkg::ST_POP: begin
            pop_vld_in  = 1'b1;
            pop_last_in = (cnt_ff == CNT_W'(1));
            cnt_in      = cnt_dec;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = itr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = itr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= itr_pkg::ST_IDLE;
         cnt_ff     <= '0;
         chunk_ff   <= '0;
         pop_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         chunk_ff   <= chunk_in;
         pop_vld_ff <= pop_vld_in;
      end
      q_ff        <= q_in;
      rem_ff      <= rem_in;
      radix_ff    <= radix_in;
      pop_last_ff <= pop_last_in;
      pop_err_ff  <= pop_err_in;
      pop_zero_ff <= pop_zero_in;
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         stack_mem[wr_addr] <= r_nx;
      end
      mem_q_ff <= stack_mem[rd_addr];
   end

   assign out_digit = pop_zero_ff ? '0 : mem_q_ff;

   always_comb begin
      if (pop_err_ff) begin
         rsp_char_in = '0;
      end else begin
         rsp_char_in = itr_pkg::digit_to_ascii(out_digit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= pop_vld_ff;
      end
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= pop_last_ff;
      rsp_error_ff <= pop_err_ff;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_error      = rsp_error_ff;

endmodule

### hw/rtl/integer_to_radix_digits_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_digits_core
// Converts a non-negative integer to upper-case ASCII digits in base 2..36,
// most significant digit first; a bad radix gives one error result.
//
//   channel   handshake           payload
//   request   start / busy        req_value[62:0], req_radix[5:0]
//   result    rsp_strobe          rsp_digit_char[6:0], rsp_last, rsp_error
//
// Each digit takes a full divider pass over all the value bits; digits are then
// popped at one per cycle and pass the stack read and result registers to the ports.
// Bad radix and zero give their single result through the holding register, the
// queue, the pop registers and the result registers.
// busy rises only when the holding register and the two-entry queue are full;
// the receiver cannot stall. Synchronous reset clears control state, not the stack.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_core #(
   parameter int VALUE_BITS = 63,
   parameter int MAX_DIGITS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [itr_pkg::VALUE_WIDTH-1:0]    req_value,
   input  logic [itr_pkg::RADIX_WIDTH-1:0]    req_radix,
   output logic                               rsp_strobe,
   output logic [itr_pkg::CHAR_WIDTH-1:0]     rsp_digit_char,
   output logic                               rsp_last,
   output logic                               rsp_error
);

   localparam int CTL_BITS  = $bits(itr_pkg::item_ctl_type);
   localparam int DATA_BITS = VALUE_BITS + CTL_BITS;

   logic                    push, queue_full, queue_empty, deq;
   itr_pkg::item_ctl_type   push_ctl, item_ctl;
   logic [VALUE_BITS-1:0]   push_value, item_value;
   logic [DATA_BITS-1:0]    push_data, pop_data;

   itr_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_value  (req_value),
      .req_radix  (req_radix),
      .push       (push),
      .queue_full (queue_full),
      .push_ctl   (push_ctl),
      .push_value (push_value)
   );

   assign push_data = {push_ctl, push_value};

   itr_queue #(
      .DATA_BITS (DATA_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (deq),
      .empty     (queue_empty),
      .pop_data  (pop_data)
   );

   assign item_ctl   = itr_pkg::item_ctl_type'(pop_data[DATA_BITS-1:VALUE_BITS]);
   assign item_value = pop_data[VALUE_BITS-1:0];

   itr_back #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (queue_empty),
      .deq            (deq),
      .item_ctl       (item_ctl),
      .item_value     (item_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last),
      .rsp_error      (rsp_error)
   );

endmodule

### dv/itr_digit_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itr_digit_check
// Watches the request and result channels of the radix digit converter.
// Each accepted request is turned into its expected ASCII digit sequence,
// most significant first. Every strobed result is compared field by field
// with the oldest expected digit.
// ----------------------------------------------------------------------------
module itr_digit_check (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic [itr_pkg::VALUE_WIDTH-1:0] req_value,
   input  logic [itr_pkg::RADIX_WIDTH-1:0] req_radix,
   input  logic                            rsp_strobe,
   input  logic [itr_pkg::CHAR_WIDTH-1:0]  rsp_digit_char,
   input  logic                            rsp_last,
   input  logic                            rsp_error,
   output int                              mismatch_count,
   output int                              digits_pending,
   output int                              digits_checked
);

   localparam int DW = itr_pkg::DIGIT_WIDTH;
   localparam int CW = itr_pkg::CHAR_WIDTH;

   typedef struct packed {
      logic [CW-1:0] digit_char;
      logic          last;
      logic          error;
   } digit_rec_type;

   digit_rec_type expected_digits[$];

   function automatic void queue_digits(input logic [itr_pkg::VALUE_WIDTH-1:0] value,
                                        input logic [itr_pkg::RADIX_WIDTH-1:0] radix);
      logic [63:0]   quotient;
      logic [63:0]   base;
      logic [DW-1:0] remainders[64];
      int            count;
      digit_rec_type rec;
      base     = 64'(radix);
      quotient = 64'(value);
      count    = 0;
      if (radix < itr_pkg::RADIX_MIN || radix > itr_pkg::RADIX_MAX) begin
         rec.digit_char = '0;
         rec.last       = 1'b1;
         rec.error      = 1'b1;
         expected_digits.push_back(rec);
         return;
      end
      if (quotient == 0) begin
         remainders[0] = '0;
         count         = 1;
      end
      while (quotient != 0) begin
         if (count < 64) begin
            remainders[count] = DW'(quotient % base);
            count++;
         end
         quotient = quotient / base;
      end
      for (int i = count - 1; i >= 0; i--) begin
         if (remainders[i] < itr_pkg::DIGIT_TEN) begin
            rec.digit_char = itr_pkg::CHAR_ZERO + CW'(remainders[i]);
         end else begin
            rec.digit_char = itr_pkg::CHAR_A + CW'(remainders[i] - itr_pkg::DIGIT_TEN);
         end
         rec.last  = (i == 0);
         rec.error = 1'b0;
         expected_digits.push_back(rec);
      end
   endfunction

   always @(posedge clock) begin
      digit_rec_type want;
      if (reset) begin
         expected_digits.delete();
         mismatch_count = 0;
         digits_checked = 0;
      end else begin
         if (start && !busy) begin
            queue_digits(req_value, req_radix);
         end
         if (rsp_strobe) begin
            if (expected_digits.size() == 0) begin
               $error("unexpected result: digit_char %0d last %0d error %0d",
                      rsp_digit_char, rsp_last, rsp_error);
               mismatch_count++;
            end else begin
               want = expected_digits.pop_front();
               digits_checked++;
               if (rsp_digit_char !== want.digit_char) begin
                  $error("digit_char: expected %0d, got %0d", want.digit_char, rsp_digit_char);
                  mismatch_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  mismatch_count++;
               end
               if (rsp_error !== want.error) begin
                  $error("error: expected %0d, got %0d", want.error, rsp_error);
                  mismatch_count++;
               end
            end
         end
      end
      digits_pending = expected_digits.size();
   end

endmodule

### dv/integer_to_radix_digits_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_digits_core_test
// Drives directed and random conversion requests into the radix digit
// converter in bursts with random gaps, while a separate checker predicts
// every digit and compares it with the strobed results.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_core_test;

   localparam int CYCLE_LIMIT     = 2_000_000;
   localparam int RANDOM_REQUESTS = 500;
   localparam int VW              = itr_pkg::VALUE_WIDTH;
   localparam int RW              = itr_pkg::RADIX_WIDTH;

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic [VW-1:0]                   req_value;
   logic [RW-1:0]                   req_radix;
   logic                            rsp_strobe;
   logic [itr_pkg::CHAR_WIDTH-1:0]  rsp_digit_char;
   logic                            rsp_last;
   logic                            rsp_error;

   int mismatch_count;
   int digits_pending;
   int digits_checked;
   int requests_sent;
   int bad_radix_sent;
   int cycle_count;

   integer_to_radix_digits_core DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .req_radix      (req_radix),
      .rsp_strobe     (rsp_strobe),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last),
      .rsp_error      (rsp_error)
   );

   itr_digit_check digit_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .req_radix      (req_radix),
      .rsp_strobe     (rsp_strobe),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last),
      .rsp_error      (rsp_error),
      .mismatch_count (mismatch_count),
      .digits_pending (digits_pending),
      .digits_checked (digits_checked)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [VW-1:0] random_value();
      logic [63:0] raw;
      logic [63:0] mask;
      int          bits;
      raw  = {$urandom, $urandom};
      bits = $urandom_range(0, VW);
      mask = (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
      if ($urandom_range(0, 15) == 0) begin
         return '0;
      end
      return VW'(raw & mask);
   endfunction

   function automatic logic [RW-1:0] random_radix();
      int pick;
      pick = $urandom_range(0, 19);
      case (pick)
         0: begin
            return RW'($urandom_range(0, 1));
         end
         1: begin
            return RW'($urandom_range(37, 63));
         end
         2: begin
            return itr_pkg::RADIX_MIN;
         end
         3: begin
            return itr_pkg::RADIX_MAX;
         end
         default: begin
            return RW'($urandom_range(2, 36));
         end
      endcase
   endfunction

   // request held until the converter is not busy at a rising edge
   task automatic send_request(input logic [VW-1:0] value,
                               input logic [RW-1:0] radix);
      @(negedge clock);
      start     <= 1'b1;
      req_value <= value;
      req_radix <= radix;
      do @(posedge clock); while (busy);
      requests_sent++;
      if (radix < itr_pkg::RADIX_MIN || radix > itr_pkg::RADIX_MAX) begin
         bad_radix_sent++;
      end
   endtask

   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         start     <= 1'b0;
         req_value <= random_value();
         req_radix <= RW'($urandom);
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   initial begin
      int sent;
      int burst;
      start          = 1'b0;
      req_value      = '0;
      req_radix      = '0;
      reset          = 1'b1;
      requests_sent  = 0;
      bad_radix_sent = 0;
      sent           = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, zero, bad radix, letter digits, bit patterns
      send_request('1, itr_pkg::RADIX_MIN);
      send_request('1, itr_pkg::RADIX_MAX);
      send_request('1, 6'd10);
      send_request('1, 6'd16);
      send_request('1, 6'd3);
      send_request('0, 6'd10);
      send_request('0, itr_pkg::RADIX_MIN);
      send_request('0, itr_pkg::RADIX_MAX);
      send_request('0, 6'd0);
      send_request('1, 6'd1);
      send_request(63'd12345, 6'd37);
      send_request('1, 6'd63);
      send_request(63'd1, itr_pkg::RADIX_MIN);
      send_request(63'd35, itr_pkg::RADIX_MAX);
      send_request(63'd36, itr_pkg::RADIX_MAX);
      send_request(63'd9, 6'd10);
      send_request(63'd10, 6'd11);
      send_request(63'h5555_5555_5555_5555, itr_pkg::RADIX_MIN);
      send_request(63'h2AAA_AAAA_AAAA_AAAA, itr_pkg::RADIX_MIN);
      send_request(63'h4000_0000_0000_0000, itr_pkg::RADIX_MAX);
      send_request(63'd1295, itr_pkg::RADIX_MAX);
      hold_off(20);

      while (sent < RANDOM_REQUESTS) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && sent < RANDOM_REQUESTS; i++) begin
            send_request(random_value(), random_radix());
            sent++;
         end
         hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40));
      end
      @(negedge clock);
      start <= 1'b0;

      while (digits_pending != 0) @(negedge clock);
      repeat (16) @(negedge clock);

      $display("Converted %0d requests (%0d with an out-of-range radix); %0d digits checked.",
               requests_sent, bad_radix_sent, digits_checked);
      if (mismatch_count == 0) begin
         $display("integer_to_radix_digits_core_test: clean");
      end else begin
         $display("integer_to_radix_digits_core_test: errors");
      end
      $finish;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d digits outstanding.",
               cycle_count, digits_pending);
      $display("integer_to_radix_digits_core_test: errors");
      $finish;
   end

endmodule
